@@ rtl/salloc_pkg.sv @@
// Shared constants, codes and types of the slot allocator.
`timescale 1ns / 1ps
package salloc_pkg;

   localparam int unsigned MAX_SLOTS  = 1024;
   localparam int unsigned SLOT_W     = $clog2(MAX_SLOTS);
   localparam int unsigned CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_RESERVE     = 2'd0;
   localparam mode_type MODE_RELEASE     = 2'd1;
   localparam mode_type MODE_RELEASE_ALL = 2'd2;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_BAD_SLOT = 2'd1;
   localparam status_type STATUS_NO_SLOT  = 2'd2;

   // Register index of init_count.
   localparam logic REG_INIT_COUNT = 1'b0;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } cfg_type;

endpackage

@@ rtl/salloc_if.sv @@
// Request and response channel interfaces of the slot allocator.
`timescale 1ns / 1ps
interface salloc_req_if;
   import salloc_pkg::*;
   logic              valid;
   logic              ready;
   mode_type          mode;
   logic [SLOT_W-1:0] slot;
   modport source (output valid, mode, slot, input ready);
   modport sink (input valid, mode, slot, output ready);
endinterface

interface salloc_rsp_if;
   import salloc_pkg::*;
   logic              valid;
   logic              ready;
   status_type        status;
   logic [SLOT_W-1:0] granted_slot;
   logic [CNT_W-1:0]  live_count;
   modport source (output valid, status, granted_slot, live_count, input ready);
   modport sink (input valid, status, granted_slot, live_count, output ready);
endinterface

@@ rtl/slot_allocator_fifo_free_list.sv @@
// Top level of the slot allocator with a first-in first-out free list.
//
//   port group   direction   handshake          contents
//   req_chan     in          valid/ready        mode, slot
//   rsp_chan     out         valid/ready        status, granted_slot, live_count
//   csr_*        in/out      APB, pready = 1    init_count at byte address 0
//
// Reserve, release and illegal modes are accepted in the idle state, which reads the
// valid-bit and link memories, and finish in the execute state, which consumes that data.
// Release-all reads the valid-bit memory once per slot of the used range,
// and reads none when the used range is empty.
// After reset and after every init_count write, a pass rewrites all MAX_SLOTS
// valid bits while req_chan.ready stays low.
// The response sits in an output register; a stalled rsp_chan holds the
// finishing operation until that register frees up.
`timescale 1ns / 1ps
module slot_allocator_fifo_free_list (
   input  logic                              clock,
   input  logic                              reset,
   salloc_req_if.sink                        req_chan,
   salloc_rsp_if.source                      rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [salloc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [salloc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [salloc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);
   import salloc_pkg::*;

   cfg_type cfg;

   salloc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   salloc_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cfg      (cfg)
   );
endmodule

@@ rtl/salloc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module salloc_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/salloc_csr.sv @@
// Configuration register block: holds init_count and signals a re-initialization.
`timescale 1ns / 1ps
module salloc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [salloc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [salloc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [salloc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output salloc_pkg::cfg_type                  cfg
);
   import salloc_pkg::*;

   logic [CNT_W-1:0] init_count_ff;
   logic [CNT_W-1:0] init_count_in;
   logic             wr_hit;
   logic [CNT_W-1:0] sat_count;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_INIT_COUNT);
   assign init_count_in = wr_hit ? csr_pwdata[CNT_W-1:0] : init_count_ff;

   // Counts above the slot capacity saturate.
   assign sat_count = (csr_pwdata[CNT_W-1:0] > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                 : csr_pwdata[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         init_count_ff <= '0;
      end else begin
         init_count_ff <= init_count_in;
      end
   end

   always_comb begin
      cfg.load  = wr_hit;
      cfg.count = sat_count;
      if (csr_paddr[2] == REG_INIT_COUNT) begin
         csr_prdata = CSR_DATA_W'(init_count_ff);
      end else begin
         csr_prdata = '0;
      end
   end
endmodule

@@ rtl/salloc_engine.sv @@
// Allocation engine: valid-bit and link memories with the free-list sequencer.
`timescale 1ns / 1ps
module salloc_engine (
   input  logic                clock,
   input  logic                reset,
   salloc_req_if.sink          req_chan,
   salloc_rsp_if.source        rsp_chan,
   input  salloc_pkg::cfg_type cfg
);
   import salloc_pkg::*;

   localparam logic [1:0] S_INIT = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_ALL  = 2'd3;

   logic [1:0]        st_ff, st_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   mode_type          mode_ff, mode_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_addr_ff, pend_addr_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [CNT_W-1:0]  used_range_ff, used_range_in;
   logic [CNT_W-1:0]  in_use_ff, in_use_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]  rsp_live_ff, rsp_live_in;

   logic              vr_we, vr_wdata, vr_re, vr_rdata;
   logic [SLOT_W-1:0] vr_waddr, vr_raddr;
   logic              lk_we, lk_re;
   logic [SLOT_W-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;

   logic              out_free;
   logic              free_go;
   logic [SLOT_W-1:0] free_slot;
   logic              rsp_load;
   status_type        res_status;
   logic [SLOT_W-1:0] res_slot;

   salloc_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_valid_ram (
      .clock (clock),
      .we    (vr_we),
      .waddr (vr_waddr),
      .wdata (vr_wdata),
      .re    (vr_re),
      .raddr (vr_raddr),
      .rdata (vr_rdata)
   );

   salloc_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_link_ram (
      .clock (clock),
      .we    (lk_we),
      .waddr (lk_waddr),
      .wdata (lk_wdata),
      .re    (lk_re),
      .raddr (lk_raddr),
      .rdata (lk_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (st_ff == S_IDLE);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.granted_slot = rsp_slot_ff;
   assign rsp_chan.live_count   = rsp_live_ff;

   always_comb begin
      st_in         = st_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      used_range_in = used_range_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_live_in   = rsp_live_ff;

      vr_we     = 1'b0;
      vr_waddr  = slot_ff;
      vr_wdata  = 1'b0;
      vr_re     = 1'b0;
      vr_raddr  = req_chan.slot;
      lk_we     = 1'b0;
      lk_waddr  = tail_ff;
      lk_wdata  = slot_ff;
      lk_re     = 1'b0;
      lk_raddr  = head_ff;
      free_go   = 1'b0;
      free_slot = slot_ff;
      rsp_load  = 1'b0;
      res_status = STATUS_OK;
      res_slot   = '0;

      unique case (st_ff)
         S_INIT: begin
            // Rewrite every valid bit: set below the initial used range.
            vr_we    = 1'b1;
            vr_waddr = clr_ff;
            vr_wdata = (CNT_W'(clr_ff) < used_range_ff);
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Both memories are read speculatively; only the next state uses the data.
            vr_re = 1'b1;
            lk_re = 1'b1;
            if (req_chan.valid) begin
               mode_in = req_chan.mode;
               slot_in = req_chan.slot;
               if (req_chan.mode == MODE_RELEASE_ALL) begin
                  st_in   = S_ALL;
                  idx_in  = '0;
                  pend_in = 1'b0;
               end else begin
                  st_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               st_in    = S_IDLE;
               rsp_load = 1'b1;
               unique case (mode_ff)
                  MODE_RESERVE: begin
                     if (!empty_ff) begin
                        if (head_ff == tail_ff) begin
                           empty_in = 1'b1;
                        end else begin
                           head_in = lk_rdata;
                        end
                        vr_we     = 1'b1;
                        vr_waddr  = head_ff;
                        vr_wdata  = 1'b1;
                        in_use_in = in_use_ff + 1'b1;
                        res_slot  = head_ff;
                     end else if (used_range_ff < CNT_W'(MAX_SLOTS)) begin
                        vr_we         = 1'b1;
                        vr_waddr      = used_range_ff[SLOT_W-1:0];
                        vr_wdata      = 1'b1;
                        used_range_in = used_range_ff + 1'b1;
                        in_use_in     = in_use_ff + 1'b1;
                        res_slot      = used_range_ff[SLOT_W-1:0];
                     end else begin
                        res_status = STATUS_NO_SLOT;
                     end
                  end
                  MODE_RELEASE: begin
                     if ((CNT_W'(slot_ff) >= used_range_ff) || !vr_rdata) begin
                        res_status = STATUS_BAD_SLOT;
                     end else begin
                        free_go   = 1'b1;
                        free_slot = slot_ff;
                     end
                  end
                  default: begin
                     res_status = STATUS_BAD_SLOT;
                  end
               endcase
            end
         end
         S_ALL: begin
            // One valid bit is read per cycle; the bit read last cycle is acted on now.
            if (idx_ff < used_range_ff) begin
               vr_re        = 1'b1;
               vr_raddr     = idx_ff[SLOT_W-1:0];
               idx_in       = idx_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[SLOT_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && vr_rdata) begin
               free_go   = 1'b1;
               free_slot = pend_addr_ff;
            end
            if (!(idx_ff < used_range_ff) && !pend_ff && out_free) begin
               st_in    = S_IDLE;
               rsp_load = 1'b1;
            end
         end
         default: begin
            st_in = S_INIT;
         end
      endcase

      if (free_go) begin
         vr_we    = 1'b1;
         vr_waddr = free_slot;
         vr_wdata = 1'b0;
         if (empty_ff) begin
            head_in  = free_slot;
            empty_in = 1'b0;
         end else begin
            lk_we    = 1'b1;
            lk_waddr = tail_ff;
            lk_wdata = free_slot;
         end
         tail_in = free_slot;
         if (in_use_ff != '0) begin
            in_use_in = in_use_ff - 1'b1;
         end
      end

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_slot_in   = res_slot;
         rsp_live_in   = in_use_in;
      end

      if (cfg.load) begin
         st_in         = S_INIT;
         clr_in        = '0;
         head_in       = '0;
         tail_in       = '0;
         empty_in      = 1'b1;
         used_range_in = cfg.count;
         in_use_in     = cfg.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_INIT;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         idx_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         used_range_ff <= '0;
         in_use_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         idx_ff        <= idx_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         used_range_ff <= used_range_in;
         in_use_ff     <= in_use_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_live_ff   <= rsp_live_in;
   end

   a_live_within_range: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= used_range_ff)
      else $error("live count exceeds used range");

   a_range_capacity: assert property (@(posedge clock) disable iff (reset)
      used_range_ff <= CNT_W'(MAX_SLOTS))
      else $error("used range exceeds slot capacity");

   a_list_ends_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (CNT_W'(head_ff) < used_range_ff) && (CNT_W'(tail_ff) < used_range_ff))
      else $error("free list end lies outside the used range");

   a_walk_done_before_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_ALL) && (st_in == S_IDLE) && !cfg.load |-> !pend_ff)
      else $error("release-all finished with a valid bit still pending");
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the slot allocator with a first-in first-out free list.
`timescale 1ns / 1ps
module testbench;
   import salloc_pkg::*;

   localparam int unsigned CLOCK_PERIOD = 12;
   localparam int unsigned STALL_LIMIT  = 20000;
   localparam int unsigned RANDOM_WORDS = 260;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam mode_type    MODE_NO_OP   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] INIT_COUNT_ADDR = {REG_INIT_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR   = 3'd4;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] granted;
      logic [CNT_W-1:0]  live;
   } outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   salloc_req_if req_bus ();
   salloc_rsp_if rsp_bus ();

   slot_allocator_fifo_free_list u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted allocator state.
   logic              slot_taken [MAX_SLOTS];
   logic [SLOT_W-1:0] free_link [MAX_SLOTS];
   logic [SLOT_W-1:0] list_head;
   logic [SLOT_W-1:0] list_tail;
   logic              list_empty;
   logic [CNT_W-1:0]  grown_range;
   logic [CNT_W-1:0]  live_slots;
   logic [CNT_W-1:0]  init_value;

   outcome_type  expected_q [$];
   int unsigned  error_count;
   int unsigned  idle_cycles;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  hold_request;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic void reinit_slots();
      int unsigned n;
      n = (init_value > MAX_SLOTS) ? MAX_SLOTS : init_value;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_taken[i] = (i < n);
         free_link[i]  = '0;
      end
      list_head   = '0;
      list_tail   = '0;
      list_empty  = 1'b1;
      grown_range = CNT_W'(n);
      live_slots  = CNT_W'(n);
   endfunction

   function automatic status_type free_slot(input logic [SLOT_W-1:0] s);
      if (!slot_taken[s])
         return STATUS_BAD_SLOT;
      slot_taken[s] = 1'b0;
      if (list_empty) begin
         list_head  = s;
         list_empty = 1'b0;
      end else begin
         free_link[list_tail] = s;
      end
      list_tail = s;
      if (live_slots != 0)
         live_slots--;
      return STATUS_OK;
   endfunction

   function automatic outcome_type apply_slot_op(input mode_type m, input logic [SLOT_W-1:0] s);
      outcome_type o;
      o = '0;
      case (m)
         MODE_RESERVE: begin
            if (!list_empty) begin
               o.granted = list_head;
               if (list_head == list_tail)
                  list_empty = 1'b1;
               else
                  list_head = free_link[list_head];
               slot_taken[o.granted] = 1'b1;
               live_slots++;
            end else if (grown_range < MAX_SLOTS) begin
               o.granted = grown_range[SLOT_W-1:0];
               slot_taken[o.granted] = 1'b1;
               grown_range++;
               live_slots++;
            end else begin
               o.status = STATUS_NO_SLOT;
            end
         end
         MODE_RELEASE: begin
            o.status = (s >= grown_range) ? STATUS_BAD_SLOT : free_slot(s);
         end
         MODE_RELEASE_ALL: begin
            for (int i = 0; i < grown_range; i++)
               void'(free_slot(SLOT_W'(i)));
         end
         default: begin
            o.status = STATUS_BAD_SLOT;
         end
      endcase
      o.live = live_slots;
      return o;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input mode_type m, input logic [SLOT_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= m;
      req_bus.slot  <= s;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      expected_q.push_back(apply_slot_op(m, s));
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (addr == INIT_COUNT_ADDR) begin
         init_value = data[CNT_W-1:0];
         reinit_slots();
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drains every outstanding result and lets the pipeline go quiet.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // About half the words are releases, most of them of slots inside the used range,
   // so the free list really gets built up and consumed.
   task automatic random_word();
      int unsigned       pick;
      logic [SLOT_W-1:0] s;
      pick = $urandom_range(99);
      s    = SLOT_W'($urandom_range(MAX_SLOTS - 1));
      if (pick < 2) begin
         send_word(MODE_RELEASE_ALL, s);
      end else if (pick < 4) begin
         send_word(MODE_NO_OP, s);
      end else if (pick < 50) begin
         send_word(MODE_RESERVE, s);
      end else begin
         if (pick < 90 && grown_range != 0)
            s = SLOT_W'($urandom_range(grown_range - 1));
         send_word(MODE_RELEASE, s);
      end
   endtask

   task automatic test_growth_and_release();
      settle();
      csr_write(INIT_COUNT_ADDR, 32'd0);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RESERVE, 10'h3FF);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RELEASE, 10'd1);
      send_word(MODE_RELEASE, 10'd1);
      send_word(MODE_RELEASE, 10'h3FF);
      send_word(MODE_RELEASE, 10'd3);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RELEASE, 10'd0);
      send_word(MODE_RELEASE, 10'd2);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_NO_OP, 10'h3FF);
      send_word(MODE_RELEASE_ALL, 10'h2AA);
      send_word(MODE_RELEASE_ALL, 10'h155);
      send_word(MODE_RESERVE, 10'd0);
   endtask

   task automatic test_full_range();
      settle();
      // The count saturates at the slot total; the upper data bits are not part of it.
      csr_write(INIT_COUNT_ADDR, 32'hFFFF_FFFF);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RELEASE, 10'h3FF);
      send_word(MODE_RELEASE, 10'd0);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RESERVE, 10'd0);
      settle();
      csr_write(INIT_COUNT_ADDR, 32'd1023);
      send_word(MODE_RESERVE, 10'd0);
      send_word(MODE_RESERVE, 10'd0);
      settle();
      csr_write(UNMAPPED_ADDR, 32'd5);
      send_word(MODE_RELEASE, 10'd7);
   endtask

   task automatic test_random_traffic(input int unsigned words, input int unsigned init,
                                      input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      settle();
      csr_write(INIT_COUNT_ADDR, init);
      repeat (words) random_word();
   endtask

   // The receiver stops for a long stretch while words keep coming, so the
   // output register and the pipeline fill up and the input stalls.
   task automatic test_backpressure();
      settle();
      hold_request = 300;
      repeat (40) random_word();
   endtask

   // Receiver: random stalls, plus the long hold-off on request.
   initial begin
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            note_failure($sformatf("result with nothing expected: status %0d slot %0d live %0d",
                                   rsp_bus.status, rsp_bus.granted_slot, rsp_bus.live_count));
         end else begin
            want = expected_q.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.granted_slot !== want.granted ||
                rsp_bus.live_count !== want.live)
               note_failure($sformatf({"mismatch: expected status %0d slot %0d live %0d, ",
                                       "got status %0d slot %0d live %0d"},
                                      want.status, want.granted, want.live, rsp_bus.status,
                                      rsp_bus.granted_slot, rsp_bus.live_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_RESERVE;
      req_bus.slot  = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      error_count   = 0;
      idle_cycles   = 0;
      hold_request  = 0;
      send_idle_pct = 9;
      recv_idle_pct = 57;
      init_value    = '0;
      reinit_slots();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_growth_and_release();
      test_full_range();
      test_random_traffic(RANDOM_WORDS, 0, 9, 57);
      test_backpressure();
      test_random_traffic(RANDOM_WORDS, 1020, 57, 9);
      test_random_traffic(RANDOM_WORDS, $urandom_range(MAX_SLOTS), 0, 0);
      settle();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
